@@ rtl/spfc_pkg.sv @@
// Package for the servo position core with feedback check.
// Field widths, reset values, register indexes, status codes and the
// controller/datapath handshake structs. No dependencies.
package spfc_pkg;

   // Field widths
   localparam int WidthUs     = 16;
   localparam int WidthOffset = 25;
   localparam int WidthMv     = 13;
   localparam int WidthMode   = 2;
   localparam int WidthStatus = 2;
   localparam int WidthMeas   = 26;
   localparam int WidthTime   = 18;
   localparam int WidthCsrIdx = 3;
   localparam int WidthCsrDat = 25;
   localparam int WidthProd   = 23;  // 8191 * 1000 fits in 23 bits
   localparam int WidthNum    = 26;  // mv*1000 - offset, signed
   localparam int WidthMag    = 25;  // magnitude of the numerator

   // Serial divider: one quotient bit per step
   localparam int DivSteps    = WidthMag;
   localparam int WidthDivCnt = $clog2(DivSteps);

   // Millivolt to microvolt scale
   localparam logic [WidthProd-1:0] MvToUv = WidthProd'(1000);

   // Default sample period
   localparam int POLL_PERIOD_DEFAULT = 100;

   // Register reset values
   localparam logic [WidthUs-1:0]     OPEN_RESET   = 16'd2000;
   localparam logic [WidthUs-1:0]     CLOSED_RESET = 16'd1000;
   localparam logic [WidthUs-1:0]     GAIN_RESET   = 16'd1;
   localparam logic [WidthOffset-1:0] OFFSET_RESET = 25'd0;
   localparam logic [WidthUs-1:0]     TOL_RESET    = 16'd50;
   localparam logic [WidthUs-1:0]     ATIME_RESET  = 16'd1000;

   // Request modes
   localparam logic [WidthMode-1:0] MODE_OPEN   = 2'd0;
   localparam logic [WidthMode-1:0] MODE_CLOSE  = 2'd1;
   localparam logic [WidthMode-1:0] MODE_SAMPLE = 2'd2;

   // Register indexes
   localparam logic [WidthCsrIdx-1:0] CSR_OPEN_WIDTH   = 3'd0;
   localparam logic [WidthCsrIdx-1:0] CSR_CLOSED_WIDTH = 3'd1;
   localparam logic [WidthCsrIdx-1:0] CSR_GAIN         = 3'd2;
   localparam logic [WidthCsrIdx-1:0] CSR_OFFSET       = 3'd3;
   localparam logic [WidthCsrIdx-1:0] CSR_TOLERANCE    = 3'd4;
   localparam logic [WidthCsrIdx-1:0] CSR_ACTION_TIME  = 3'd5;

   // Result status codes
   typedef enum logic [WidthStatus-1:0] {
      STATUS_NONE    = 2'd0,
      STATUS_REACHED = 2'd1,
      STATUS_TIMEOUT = 2'd2,
      STATUS_FAULT   = 2'd3
   } status_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;    // latch request and set up divider
      logic step;    // one divider iteration
      logic commit;  // update state, fill output register
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_div;  // request is a good sample during an action
   } dp_status_type;

endpackage

@@ rtl/spfc_ifs.sv @@
// Valid/ready channel interfaces for the servo position core.
// Depends on spfc_pkg.

// Request channel
interface spfc_req_if import spfc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WidthMode-1:0] mode;
   logic [WidthMv-1:0]   feedback_mv;
   logic                 feedback_fault;

   modport source (output valid, mode, feedback_mv, feedback_fault, input ready);
   modport sink   (input valid, mode, feedback_mv, feedback_fault, output ready);
endinterface

// Result channel
interface spfc_rsp_if import spfc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [WidthUs-1:0]            drive_width_us;
   logic                          busy_res;
   logic [WidthStatus-1:0]        status;
   logic signed [WidthMeas-1:0]   measured_us;

   modport source (output valid, drive_width_us, busy_res, status, measured_us,
                   input ready);
   modport sink   (input valid, drive_width_us, busy_res, status, measured_us,
                   output ready);
endinterface

// Register write channel
interface spfc_csr_if import spfc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [WidthCsrIdx-1:0] index;
   logic [WidthCsrDat-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/spfc_ctrl.sv @@
// Controller for the servo position core: accepts a request, sequences
// the serial divider, commits into the output register. Depends on spfc_pkg.
module spfc_ctrl import spfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EVAL
   } state_type;

   state_type              state_ff;
   logic [WidthDivCnt-1:0] cnt_ff;
   logic                   rsp_valid_ff;
   logic                   out_free;

   // Output register may be refilled when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Commands
   always_comb begin
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.step   = (state_ff == ST_DIV);
      cmd.commit = (state_ff == ST_EVAL) && out_free;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // State, iteration count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cnt_ff   <= '0;
                  state_ff <= dp_status.need_div ? ST_DIV : ST_EVAL;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == WidthDivCnt'(DivSteps - 1)) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ rtl/spfc_datapath.sv @@
// Datapath for the servo position core: registers, action state, serial
// restoring divider, window check and output register. Depends on spfc_pkg.
module spfc_datapath import spfc_pkg::*; #(
   parameter int POLL_PERIOD_MS = POLL_PERIOD_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // register writes
   input  logic                        csr_write,
   input  logic [WidthCsrIdx-1:0]      csr_index,
   input  logic [WidthCsrDat-1:0]      csr_data,
   // request payload
   input  logic [WidthMode-1:0]        req_mode,
   input  logic [WidthMv-1:0]          req_feedback_mv,
   input  logic                        req_feedback_fault,
   // result payload
   output logic [WidthUs-1:0]          rsp_drive_width_us,
   output logic                        rsp_busy_res,
   output logic [WidthStatus-1:0]      rsp_status,
   output logic signed [WidthMeas-1:0] rsp_measured_us,
   // controller link
   input  ctrl_cmd_type                cmd,
   output dp_status_type               dp_status
);

   localparam logic [WidthTime-1:0] PollMs = WidthTime'(POLL_PERIOD_MS);

   // Configuration registers
   logic [WidthUs-1:0]     open_ff, closed_ff, gain_ff, tol_ff, atime_ff;
   logic [WidthOffset-1:0] offset_ff;

   // Action state
   logic                 active_ff, active_in;
   logic [WidthUs-1:0]   target_ff, target_in;
   logic [WidthTime-1:0] time_left_ff, time_left_in;
   logic [WidthUs-1:0]   drive_ff, drive_in;

   // Latched request and divider
   logic [WidthMode-1:0] mode_ff;
   logic                 div_used_ff;
   logic                 neg_ff;
   logic [WidthUs-1:0]   dvs_ff;
   logic [WidthUs-1:0]   rem_ff;
   logic [WidthMag-1:0]  quo_ff;

   // Output register
   logic [WidthUs-1:0]          out_drive_ff;
   logic                        out_busy_ff;
   status_type                  out_status_ff, status_in;
   logic signed [WidthMeas-1:0] out_meas_ff, meas_in;

   logic [WidthProd-1:0]       prod;
   logic signed [WidthNum-1:0] num;
   logic [WidthMag-1:0]        num_abs;
   logic [WidthUs:0]           trial;
   logic [WidthUs:0]           trial_sub;
   logic signed [WidthMeas-1:0] measured;
   logic signed [WidthMeas+1:0] diff;
   logic signed [WidthMeas+1:0] tol_s;
   logic                        in_window;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= OPEN_RESET;
         closed_ff <= CLOSED_RESET;
         gain_ff   <= GAIN_RESET;
         offset_ff <= OFFSET_RESET;
         tol_ff    <= TOL_RESET;
         atime_ff  <= ATIME_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_OPEN_WIDTH:   open_ff   <= csr_data[WidthUs-1:0];
            CSR_CLOSED_WIDTH: closed_ff <= csr_data[WidthUs-1:0];
            CSR_GAIN:         gain_ff   <= csr_data[WidthUs-1:0];
            CSR_OFFSET:       offset_ff <= csr_data[WidthOffset-1:0];
            CSR_TOLERANCE:    tol_ff    <= csr_data[WidthUs-1:0];
            CSR_ACTION_TIME:  atime_ff  <= csr_data[WidthUs-1:0];
            default: ;
         endcase
      end
   end

   // Good sample during an action goes through the divider
   assign dp_status.need_div = (req_mode == MODE_SAMPLE) && active_ff
                               && !req_feedback_fault;

   // Numerator mv*1000 - offset and its magnitude
   assign prod    = WidthProd'(req_feedback_mv) * MvToUv;
   assign num     = $signed({3'b000, prod}) - $signed({offset_ff[WidthOffset-1], offset_ff});
   assign num_abs = num[WidthNum-1] ? WidthMag'(-num) : WidthMag'(num);

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial     = {rem_ff, quo_ff[WidthMag-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};

   // Load and divider iterations
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff     <= req_mode;
         div_used_ff <= dp_status.need_div;
         neg_ff      <= num[WidthNum-1];
         dvs_ff      <= (gain_ff == '0) ? WidthUs'(1) : gain_ff;
         rem_ff      <= '0;
         quo_ff      <= num_abs;
      end else if (cmd.step) begin
         if (!trial_sub[WidthUs]) begin
            rem_ff <= trial_sub[WidthUs-1:0];
            quo_ff <= {quo_ff[WidthMag-2:0], 1'b1};
         end else begin
            rem_ff <= trial[WidthUs-1:0];
            quo_ff <= {quo_ff[WidthMag-2:0], 1'b0};
         end
      end
   end

   // Signed quotient and window check against the target
   assign measured  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign diff      = $signed({{2{measured[WidthMeas-1]}}, measured})
                      - $signed({(WidthMeas + 2 - WidthUs)'(0), target_ff});
   assign tol_s     = $signed({(WidthMeas + 2 - WidthUs)'(0), tol_ff});
   assign in_window = (diff <= tol_s) && (diff >= -tol_s);

   // Next action state and result
   always_comb begin
      active_in    = active_ff;
      target_in    = target_ff;
      time_left_in = time_left_ff;
      drive_in     = drive_ff;
      status_in    = STATUS_NONE;
      meas_in      = '0;
      case (mode_ff)
         MODE_OPEN, MODE_CLOSE: begin
            target_in    = (mode_ff == MODE_OPEN) ? open_ff : closed_ff;
            drive_in     = target_in;
            time_left_in = WidthTime'(atime_ff);
            active_in    = 1'b1;
         end
         MODE_SAMPLE: begin
            if (active_ff) begin
               if (!div_used_ff) begin
                  // feedback fault: end the action, keep the drive
                  status_in = STATUS_FAULT;
                  active_in = 1'b0;
               end else begin
                  meas_in = measured;
                  if (in_window) begin
                     status_in    = STATUS_REACHED;
                     active_in    = 1'b0;
                     drive_in     = '0;
                     time_left_in = '0;
                  end else if (time_left_ff <= PollMs) begin
                     status_in    = STATUS_TIMEOUT;
                     active_in    = 1'b0;
                     drive_in     = '0;
                     time_left_in = '0;
                  end else begin
                     time_left_in = time_left_ff - PollMs;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Action state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         target_ff    <= '0;
         time_left_ff <= '0;
         drive_ff     <= '0;
      end else if (cmd.commit) begin
         active_ff    <= active_in;
         target_ff    <= target_in;
         time_left_ff <= time_left_in;
         drive_ff     <= drive_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_drive_ff  <= drive_in;
         out_busy_ff   <= active_in;
         out_status_ff <= status_in;
         out_meas_ff   <= meas_in;
      end
   end

   assign rsp_drive_width_us = out_drive_ff;
   assign rsp_busy_res       = out_busy_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_measured_us    = out_meas_ff;

endmodule

@@ rtl/servo_position_with_feedback_check_core.sv @@
// Servo position core with feedback check: a command, an ignored sample or a
// fault is latched on acceptance and its result committed to the output register
// once that is free; a feedback sample during an action first runs the 25-step
// serial divider. One request in flight: the next is taken once the result is
// committed; the result may still wait on the result channel meanwhile.
// Synchronous active-high reset restores register defaults and idle state.
module servo_position_with_feedback_check_core import spfc_pkg::*; #(
   parameter int POLL_PERIOD_MS = POLL_PERIOD_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   spfc_req_if.sink   req_ch,
   spfc_rsp_if.source rsp_ch,
   spfc_csr_if.sink   csr_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   spfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   spfc_datapath #(
      .POLL_PERIOD_MS (POLL_PERIOD_MS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .req_mode           (req_ch.mode),
      .req_feedback_mv    (req_ch.feedback_mv),
      .req_feedback_fault (req_ch.feedback_fault),
      .rsp_drive_width_us (rsp_ch.drive_width_us),
      .rsp_busy_res       (rsp_ch.busy_res),
      .rsp_status         (rsp_ch.status),
      .rsp_measured_us    (rsp_ch.measured_us),
      .cmd                (cmd),
      .dp_status          (dp_status)
   );

endmodule

@@ rtl/spfc_checker.sv @@
// Port-level checks for the servo position core, bound to the top level.
// Depends on spfc_pkg and servo_position_with_feedback_check_core.
module spfc_checker import spfc_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [WidthUs-1:0]          rsp_drive_width_us,
   input logic                        rsp_busy_res,
   input logic [WidthStatus-1:0]      rsp_status,
   input logic signed [WidthMeas-1:0] rsp_measured_us
);

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive_width_us)
         && $stable(rsp_busy_res) && $stable(rsp_status) && $stable(rsp_measured_us))
      else $error("stalled result changed");

   // One request at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in progress");

   // An ended action is not busy; reached or timed out stops the drive
   a_end_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_REACHED || rsp_status == STATUS_TIMEOUT)
         |-> !rsp_busy_res && rsp_drive_width_us == '0)
      else $error("ended action still driving");

   // A measurement comes with a window decision or a still running action
   a_meas_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_measured_us != '0
         |-> (rsp_status == STATUS_REACHED || rsp_status == STATUS_TIMEOUT
              || (rsp_status == STATUS_NONE && rsp_busy_res)))
      else $error("measurement outside a feedback sample of an action");

endmodule

bind servo_position_with_feedback_check_core spfc_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_drive_width_us (rsp_ch.drive_width_us),
   .rsp_busy_res       (rsp_ch.busy_res),
   .rsp_status         (rsp_ch.status),
   .rsp_measured_us    (rsp_ch.measured_us)
);
